/* sv/epoch_seconds_to_calendar_assert.svh */
// Assertion macros used by the calendar converter controller.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar converter check failed");

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar converter check failed");

`endif

/* sv/esc_pkg.sv */
`default_nettype none

package esc_pkg;

  // Field widths of the request and result.
  localparam int unsigned EpochW  = 32;
  localparam int unsigned ZoneW   = 5;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // Internal widths: whole days since 1970 and whole minutes of the day.
  localparam int unsigned DaysW = 16;
  localparam int unsigned MinsW = 11;

  localparam logic [EpochW-1:0] Y2kSeconds    = 32'd946684800;
  localparam logic [16:0]       SecsPerDay    = 17'd86400;
  localparam logic [16:0]       SecsPerMinute = 17'd60;
  localparam logic [MinsW-1:0]  MinsPerHour   = 11'd60;
  localparam logic [YearW-1:0]  BaseYear      = 12'd1970;

  // Reciprocals for the constant divisions. The count shifted right by 7 times
  // DayRecip, shifted right by 35, gives whole days. The time of day shifted
  // right by 2 times MinRecip, shifted right by 19, gives whole minutes, and
  // shifted right by 4 times HourRecip, shifted right by 21, gives whole hours.
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [15:0] MinRecip  = 16'd34953;
  localparam logic [13:0] HourRecip = 14'd9321;

  // Year 1970 taken modulo 4, 100 and 400.
  localparam logic [1:0] BaseMod4   = 2'd2;
  localparam logic [6:0] BaseMod100 = 7'd70;
  localparam logic [8:0] BaseMod400 = 9'd370;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DAY_QUO,
    CMD_DAY_REM,
    CMD_TOD_QUO,
    CMD_TOD_REM,
    CMD_YEAR,
    CMD_MONTH,
    CMD_FINISH
  } esc_cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic year_fit;
    logic month_fit;
  } esc_status_t;

  // One result item.
  typedef struct packed {
    logic               valid_res;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } esc_result_t;

  // Days in a month of a year whose leap flag is given.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (month == MonthFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month == MonthApr || month == MonthJun ||
                 month == MonthSep || month == MonthNov) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* sv/esc_in_if.sv */
`default_nettype none

// Request channel carrying one seconds count.
interface esc_in_if;
  import esc_pkg::*;

  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

/* sv/esc_out_if.sv */
`default_nettype none

// Result channel carrying one calendar date and time.
interface esc_out_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;

  modport source (output valid, output valid_res, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink (input valid, input valid_res, input year, input month, input day,
                input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

/* sv/esc_ctrl.sv */
`default_nettype none

`include "epoch_seconds_to_calendar_assert.svh"

module esc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire esc_pkg::esc_status_t status_i,
  output esc_pkg::esc_cmd_e        cmd_o
);
  import esc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY_QUO,
    S_DAY_REM,
    S_TOD_QUO,
    S_TOD_REM,
    S_YEAR,
    S_MONTH,
    S_FINISH,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // Next state and command to the datapath.
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DAY_QUO;
        end
      end
      S_DAY_QUO: begin
        if (status_i.reject) begin
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_DAY_QUO;
          state_d = S_DAY_REM;
        end
      end
      S_DAY_REM: begin
        cmd_o   = CMD_DAY_REM;
        state_d = S_TOD_QUO;
      end
      S_TOD_QUO: begin
        cmd_o   = CMD_TOD_QUO;
        state_d = S_TOD_REM;
      end
      S_TOD_REM: begin
        cmd_o   = CMD_TOD_REM;
        state_d = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_fit) begin
          state_d = S_MONTH;
        end else begin
          cmd_o = CMD_YEAR;
        end
      end
      S_MONTH: begin
        if (status_i.month_fit) begin
          state_d = S_FINISH;
        end else begin
          cmd_o = CMD_MONTH;
        end
      end
      S_FINISH: begin
        cmd_o   = CMD_FINISH;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // A request is never taken while a result is on offer.
  `ESC_ASSERT_SAME(a_ready_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // A taken request closes the input until its result has gone.
  `ESC_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A delivered result reopens the input at once.
  `ESC_ASSERT_NEXT(a_idle_after_out, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)

endmodule

`default_nettype wire

/* sv/esc_dp.sv */
`default_nettype none

module esc_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [esc_pkg::ZoneW-1:0] cfg_wdata_i,
  input  wire logic [esc_pkg::EpochW-1:0] epoch_seconds_i,
  input  wire esc_pkg::esc_cmd_e         cmd_i,
  output esc_pkg::esc_status_t           status_o,
  output esc_pkg::esc_result_t           result_o
);
  import esc_pkg::*;

  logic [ZoneW-1:0]   zone_q;
  logic               reject_q;
  logic [EpochW-1:0]  rem_q;
  logic [DaysW-1:0]   days_q;
  logic [MinsW-1:0]   mins_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic [YearW-1:0]   year_q;
  logic [MonthW-1:0]  month_q;
  logic [1:0]         mod4_q;
  logic [6:0]         mod100_q;
  logic [8:0]         mod400_q;
  esc_result_t        result_q;

  logic signed [17:0] offset_s;
  logic [EpochW-1:0]  adjusted;
  logic [50:0]        day_prod;
  logic [32:0]        day_total;
  logic [29:0]        min_prod;
  logic [25:0]        hour_prod;
  logic [16:0]        sec_total;
  logic [MinsW-1:0]   min_total;
  logic               leap;
  logic [8:0]         year_len;
  logic [DayW-1:0]    mon_len;

  // Zone offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
    end else if (cfg_we_i) begin
      zone_q <= cfg_wdata_i;
    end
  end

  // Offset in seconds, added with wrap modulo 2^32.
  assign offset_s = 18'(signed'(zone_q)) * 18'sd3600;
  assign adjusted = epoch_seconds_i + EpochW'(unsigned'(32'(offset_s)));

  // Quotients by reciprocal multiplication and the products taken back off.
  assign day_prod  = 51'(rem_q[EpochW-1:7]) * 51'(DayRecip);
  assign day_total = 33'(days_q) * 33'(SecsPerDay);
  assign min_prod  = 30'(rem_q[16:2]) * 30'(MinRecip);
  assign hour_prod = 26'(rem_q[16:4]) * 26'(HourRecip);
  assign sec_total = 17'(mins_q) * SecsPerMinute;
  assign min_total = MinsW'(hour_q) * MinsPerHour;

  // Gregorian year and month lengths.
  assign leap     = (mod400_q == 9'd0) || ((mod4_q == 2'd0) && (mod100_q != 7'd0));
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mon_len  = month_len(month_q, leap);

  assign status_o.reject    = reject_q;
  assign status_o.year_fit  = days_q < DaysW'(year_len);
  assign status_o.month_fit = (days_q < DaysW'(mon_len)) || (month_q == MonthDec);

  // Working registers, driven by the controller's command.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        reject_q <= epoch_seconds_i < Y2kSeconds;
        rem_q    <= adjusted;
        year_q   <= BaseYear;
        month_q  <= 4'd1;
        mod4_q   <= BaseMod4;
        mod100_q <= BaseMod100;
        mod400_q <= BaseMod400;
      end
      CMD_DAY_QUO: begin
        days_q <= day_prod[50:35];
      end
      CMD_DAY_REM: begin
        rem_q <= rem_q - day_total[EpochW-1:0];
      end
      CMD_TOD_QUO: begin
        mins_q <= min_prod[29:19];
        hour_q <= hour_prod[25:21];
      end
      CMD_TOD_REM: begin
        rem_q    <= rem_q - EpochW'(sec_total);
        minute_q <= MinuteW'(mins_q - min_total);
      end
      CMD_YEAR: begin
        if (days_q >= DaysW'(year_len)) begin
          days_q   <= days_q - DaysW'(year_len);
          year_q   <= year_q + 12'd1;
          mod4_q   <= mod4_q + 2'd1;
          mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
          mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
        end
      end
      CMD_MONTH: begin
        if (days_q >= DaysW'(mon_len)) begin
          days_q  <= days_q - DaysW'(mon_len);
          month_q <= month_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register, all fields cleared for a rejected count.
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_FINISH) begin
      if (reject_q) begin
        result_q <= '0;
      end else begin
        result_q.valid_res <= 1'b1;
        result_q.year      <= year_q;
        result_q.month     <= month_q;
        result_q.day       <= days_q[DayW-1:0] + 5'd1;
        result_q.hour      <= hour_q;
        result_q.minute    <= minute_q;
        result_q.second    <= rem_q[SecondW-1:0];
      end
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

/* sv/epoch_seconds_to_calendar.sv */
// A rejected request goes from the day quotient state straight to finish; any other
// steps through day quotient and remainder, time-of-day quotient and remainder,
// a year loop over whole years since 1970 (up to 136), a month loop over whole
// months in the final year (up to 11), then finish. One request at a time; the
// next is taken in the cycle after the result leaves. Quotients use reciprocals.
// Reset clears the controller and sets the zone offset to zero.
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [esc_pkg::ZoneW-1:0] cfg_wdata_i,
  esc_in_if.sink                         in_i,
  esc_out_if.source                      out_o
);
  import esc_pkg::*;

  esc_cmd_e    cmd;
  esc_status_t status;
  esc_result_t result;

  // Sequencer.
  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and result register.
  esc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .epoch_seconds_i (in_i.epoch_seconds),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result)
  );

  assign out_o.valid_res = result.valid_res;
  assign out_o.year      = result.year;
  assign out_o.month     = result.month;
  assign out_o.day       = result.day;
  assign out_o.hour      = result.hour;
  assign out_o.minute    = result.minute;
  assign out_o.second    = result.second;

endmodule

`default_nettype wire
